/* design/cbs_pkg.sv */
// Shared types and constants of the cubic B-spline sampler.
`default_nettype none
package cbs_pkg;

  localparam int CW        = 16;
  localparam int VW        = CW + 1;
  localparam int AW        = CW + 2;
  localparam int STEPS_W   = 7;
  localparam int MAX_STEPS = 64;
  localparam int STEPS_RST = 64;
  localparam int JW        = 6;
  localparam int WW        = 24;
  localparam int MACW      = 42;
  localparam int MW        = 48;
  localparam int QW        = 19;
  localparam int QSW       = QW + 2;
  localparam int SQW       = 36;
  localparam int SQRT_IT   = 18;
  localparam int CNT_W     = 5;
  localparam int LEN_W     = 32;
  localparam int DIST_W    = 18;
  localparam int IN_DW     = 48;
  localparam int OUT_DW    = 192;

  typedef enum logic [1:0] {
    K_POS = 2'd0,
    K_VEL = 2'd1,
    K_ACC = 2'd2
  } kind_t;

  typedef struct packed {
    logic       accept;
    logic       n_load;
    logic       n2_calc;
    logic       n3_calc;
    logic       w1;
    logic       w2;
    logic       w3;
    logic       mac;
    logic       dpre;
    logic       div_step;
    logic       dpost;
    logic       sq;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       emit;
    logic       j_next;
    logic       shift;
    logic [1:0] comp;
    kind_t      kind;
    logic [1:0] tap;
  } cmd_t;

  typedef struct packed {
    logic seg_go;
    logic out_free;
    logic last_j;
  } status_t;

endpackage
`default_nettype wire

/* design/cubic_bspline_sampler_core.sv */
// Top level of the uniform cubic B-spline sampler.
//
//  channel | dir | handshake              | word
//  in      | in  | in_tvalid / in_tready   | tdata cx,cy,cz; tuser start_curve
//  out     | out | out_tvalid / out_tready | tdata pos,vel,acc,arc; tlast last
//  cfg     | in  | cfg_valid / cfg_ready   | cfg_data = steps
//
// The first three points of a curve are only stored and give no word.
// Each later point gives n samples: per sample nine multiply-accumulates
// and restoring divisions, then an 18-step square root for the arc
// length; the single divider sets the rate.
// Reset is synchronous and restores steps to 64 and clears the curve history.
// A stalled out channel holds the sequencer before its next word.
`default_nettype none
module cubic_bspline_sampler_core
  import cbs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_DW-1:0]  in_tdata,   // cx, cy, cz
  input  wire logic              in_tuser,   // start_curve
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_DW-1:0]      out_tdata,  // pos_x,y,z, vel_x,y,z, acc_x,y,z, arc_length, 0
  output logic                   out_tlast,  // last_sample
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [STEPS_W-1:0] cfg_data
);

  cmd_t                 cmd;
  status_t              sts;
  logic signed [CW-1:0] o_pos [0:2];
  logic signed [VW-1:0] o_vel [0:2];
  logic signed [AW-1:0] o_acc [0:2];
  logic [LEN_W-1:0]     o_len;

  assign cfg_ready = 1'b1;

  cbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cbs_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_steps (cfg_data),
    .in_start  (in_tuser),
    .in_x      (in_tdata[CW-1:0]),
    .in_y      (in_tdata[2*CW-1:CW]),
    .in_z      (in_tdata[3*CW-1:2*CW]),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .o_pos     (o_pos),
    .o_vel     (o_vel),
    .o_acc     (o_acc),
    .o_len     (o_len),
    .o_last    (out_tlast)
  );

  assign out_tdata = {7'd0, o_len,
                      o_acc[2], o_acc[1], o_acc[0],
                      o_vel[2], o_vel[1], o_vel[0],
                      o_pos[2], o_pos[1], o_pos[0]};

endmodule
`default_nettype wire

/* design/cbs_ctrl.sv */
// Sequencer of the cubic B-spline sampler.
`default_nettype none
module cbs_ctrl
  import cbs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  status_t      sts,
  output cmd_t         cmd
);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_N     = 16'h0002,
    S_N2    = 16'h0004,
    S_N3    = 16'h0008,
    S_W1    = 16'h0010,
    S_W2    = 16'h0020,
    S_W3    = 16'h0040,
    S_MAC   = 16'h0080,
    S_DPRE  = 16'h0100,
    S_DIV   = 16'h0200,
    S_DPOST = 16'h0400,
    S_SQ    = 16'h0800,
    S_SQI   = 16'h1000,
    S_SQRT  = 16'h2000,
    S_EMIT  = 16'h4000,
    S_SHIFT = 16'h8000
  } state_t;

  state_t           state_r, state_nxt;
  logic [1:0]       comp_r, comp_nxt;
  kind_t            kind_r, kind_nxt;
  logic [1:0]       tap_r, tap_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    comp_nxt  = comp_r;
    kind_nxt  = kind_r;
    tap_nxt   = tap_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.comp  = comp_r;
    cmd.kind  = kind_r;
    cmd.tap   = tap_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && sts.seg_go) state_nxt = S_N;
      end
      S_N: begin
        cmd.n_load = 1'b1;
        state_nxt  = S_N2;
      end
      S_N2: begin
        cmd.n2_calc = 1'b1;
        state_nxt   = S_N3;
      end
      S_N3: begin
        cmd.n3_calc = 1'b1;
        state_nxt   = S_W1;
      end
      S_W1: begin
        cmd.w1    = 1'b1;
        state_nxt = S_W2;
      end
      S_W2: begin
        cmd.w2    = 1'b1;
        state_nxt = S_W3;
      end
      S_W3: begin
        cmd.w3    = 1'b1;
        comp_nxt  = 2'd0;
        kind_nxt  = K_POS;
        tap_nxt   = 2'd0;
        state_nxt = S_MAC;
      end
      S_MAC: begin
        cmd.mac = 1'b1;
        tap_nxt = tap_r + 2'd1;
        if (tap_r == 2'd3) state_nxt = S_DPRE;
      end
      S_DPRE: begin
        cmd.dpre  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QW - 1)) state_nxt = S_DPOST;
      end
      S_DPOST: begin
        cmd.dpost = 1'b1;
        tap_nxt   = 2'd0;
        state_nxt = S_MAC;
        if (kind_r == K_ACC) begin
          kind_nxt = K_POS;
          if (comp_r == 2'd2) begin
            comp_nxt  = 2'd0;
            state_nxt = S_SQ;
          end else begin
            comp_nxt = comp_r + 2'd1;
          end
        end else begin
          kind_nxt = (kind_r == K_POS) ? K_VEL : K_ACC;
        end
      end
      S_SQ: begin
        cmd.sq   = 1'b1;
        comp_nxt = comp_r + 2'd1;
        if (comp_r == 2'd2) begin
          comp_nxt  = 2'd0;
          state_nxt = S_SQI;
        end
      end
      S_SQI: begin
        cmd.sqrt_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQRT_IT - 1)) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last_j) begin
            state_nxt = S_SHIFT;
          end else begin
            cmd.j_next = 1'b1;
            state_nxt  = S_W1;
          end
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      comp_r  <= 2'd0;
      kind_r  <= K_POS;
      tap_r   <= 2'd0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      comp_r  <= comp_nxt;
      kind_r  <= kind_nxt;
      tap_r   <= tap_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

/* design/cbs_dpath.sv */
// Arithmetic, history and result register of the cubic B-spline sampler.
`default_nettype none
module cbs_dpath
  import cbs_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  cmd_t                          cmd,
  output status_t                       sts,
  input  wire logic                     cfg_we,
  input  wire logic [STEPS_W-1:0]       cfg_steps,
  input  wire logic                     in_start,
  input  wire logic signed [CW-1:0]     in_x,
  input  wire logic signed [CW-1:0]     in_y,
  input  wire logic signed [CW-1:0]     in_z,
  input  wire logic                     out_ready,
  output logic                          out_valid,
  output logic signed [CW-1:0]          o_pos [0:2],
  output logic signed [VW-1:0]          o_vel [0:2],
  output logic signed [AW-1:0]          o_acc [0:2],
  output logic [LEN_W-1:0]              o_len,
  output logic                          o_last
);

  function automatic logic signed [QSW-1:0] sat_q(input logic signed [QSW-1:0] q,
                                                  input int w);
    logic signed [QSW-1:0] hi;
    logic signed [QSW-1:0] lo;
    hi = QSW'((64'sd1 <<< (w - 1)) - 64'sd1);
    lo = -hi - QSW'(1);
    if (q > hi) return hi;
    if (q < lo) return lo;
    return q;
  endfunction

  logic [STEPS_W-1:0]     steps_r;
  logic signed [CW-1:0]   hist_r [0:2][0:2];
  logic signed [CW-1:0]   p3_r [0:2];
  logic [1:0]             held_r;
  logic [1:0]             held_eff;
  logic signed [CW-1:0]   pt [0:2];

  logic [STEPS_W-1:0]     n_r;
  logic [12:0]            n2_r;
  logic [18:0]            n3_r;
  logic [JW-1:0]          j_r;
  logic [STEPS_W-1:0]     m;
  logic [11:0]            j2_r;
  logic [12:0]            jn_r;
  logic [12:0]            m2_r;
  logic [17:0]            j3_r;
  logic [17:0]            j2n_r;
  logic [18:0]            jn2_r;
  logic [18:0]            m3_r;
  logic signed [WW-1:0]   w_r [0:2][0:3];

  logic signed [WW-1:0]   tj, tn, tn2, tn3, tj2, tj3, tjn, tj2n, tjn2, tm2, tm3;
  logic signed [CW-1:0]   ptap;
  logic signed [WW+CW-1:0] prod;
  logic signed [MACW-1:0] mac_r;

  logic [MW-1:0]          den;
  logic signed [MW-1:0]   a_s;
  logic [MW-1:0]          mag;
  logic [MW-1:0]          rem_r;
  logic [MW-1:0]          dvs_r;
  logic [QW-1:0]          quo_r;
  logic                   neg_r;
  logic                   ovf_r;
  logic [QW-1:0]          qm;
  logic signed [QSW-1:0]  qmag;
  logic signed [QSW-1:0]  qv;

  logic signed [CW-1:0]   pos_r [0:2];
  logic signed [VW-1:0]   vel_r [0:2];
  logic signed [AW-1:0]   acc_r [0:2];
  logic signed [CW-1:0]   prev_r [0:2];
  logic                   have_prev_r;

  logic signed [CW:0]     d;
  logic [CW:0]            ad;
  logic [SQW-1:0]         sq_r;
  logic [SQW-1:0]         s_r, r_r, bit_r;
  logic [SQW-1:0]         rb;
  logic [DIST_W-1:0]      seg_dist;
  logic [LEN_W:0]         sum;
  logic [LEN_W-1:0]       len_r;
  logic                   out_valid_r;

  assign pt[0] = in_x;
  assign pt[1] = in_y;
  assign pt[2] = in_z;

  assign held_eff     = in_start ? 2'd0 : held_r;
  assign sts.seg_go   = (held_eff == 2'd3);
  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.last_j   = ({1'b0, j_r} == (n_r - STEPS_W'(1)));
  assign out_valid    = out_valid_r;

  assign m    = n_r - {1'b0, j_r};
  assign tj   = WW'(j_r);
  assign tn   = WW'(n_r);
  assign tn2  = WW'(n2_r);
  assign tn3  = WW'(n3_r);
  assign tj2  = WW'(j2_r);
  assign tj3  = WW'(j3_r);
  assign tjn  = WW'(jn_r);
  assign tj2n = WW'(j2n_r);
  assign tjn2 = WW'(jn2_r);
  assign tm2  = WW'(m2_r);
  assign tm3  = WW'(m3_r);

  assign ptap = (cmd.tap == 2'd3) ? p3_r[cmd.comp] : hist_r[cmd.tap][cmd.comp];
  assign prod = w_r[cmd.kind][cmd.tap] * ptap;

  always_comb begin
    case (cmd.kind)
      K_POS:   den = MW'({n3_r, 2'b00}) + MW'({n3_r, 1'b0});
      K_VEL:   den = MW'({n2_r, 1'b0});
      K_ACC:   den = MW'(n_r);
      default: den = MW'(n_r);
    endcase
  end

  assign a_s  = (MW'(mac_r) <<< 1) + $signed(den);
  assign mag  = a_s[MW-1] ? MW'(-a_s) : MW'(a_s);

  assign qm   = ovf_r ? {QW{1'b1}} : quo_r;
  assign qmag = $signed({2'b00, qm}) + QSW'(ovf_r || (rem_r != '0));
  assign qv   = neg_r ? -qmag : $signed({2'b00, qm});

  assign d  = have_prev_r ? ((CW+1)'(pos_r[cmd.comp]) - (CW+1)'(prev_r[cmd.comp]))
                          : '0;
  assign ad = d[CW] ? (CW+1)'(-d) : (CW+1)'(d);

  assign rb       = r_r + bit_r;
  assign seg_dist = DIST_W'(r_r) + DIST_W'(s_r > r_r);
  assign sum      = {1'b0, len_r} + (LEN_W+1)'(seg_dist);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r     <= STEPS_W'(STEPS_RST);
      held_r      <= 2'd0;
      have_prev_r <= 1'b0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) steps_r <= cfg_steps;
      if (cmd.accept) begin
        if (in_start) begin
          have_prev_r <= 1'b0;
          len_r       <= '0;
        end
        if (held_eff != 2'd3) held_r <= held_eff + 2'd1;
        else held_r <= held_eff;
      end
      if (cmd.emit) begin
        have_prev_r <= 1'b1;
        len_r       <= sum[LEN_W] ? {LEN_W{1'b1}} : sum[LEN_W-1:0];
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      for (int c = 0; c < 3; c++) begin
        if (held_eff != 2'd3) hist_r[held_eff][c] <= pt[c];
        else p3_r[c] <= pt[c];
      end
    end
    if (cmd.shift) begin
      for (int c = 0; c < 3; c++) begin
        hist_r[0][c] <= hist_r[1][c];
        hist_r[1][c] <= hist_r[2][c];
        hist_r[2][c] <= p3_r[c];
      end
    end
    if (cmd.n_load) begin
      if (steps_r == '0) n_r <= STEPS_W'(1);
      else if (steps_r > STEPS_W'(MAX_STEPS)) n_r <= STEPS_W'(MAX_STEPS);
      else n_r <= steps_r;
      j_r <= '0;
    end
    if (cmd.n2_calc) n2_r <= 13'(n_r * n_r);
    if (cmd.n3_calc) n3_r <= 19'(n2_r * n_r);
    if (cmd.j_next) j_r <= j_r + JW'(1);
    if (cmd.w1) begin
      j2_r <= 12'(j_r * j_r);
      jn_r <= 13'(j_r * n_r);
      m2_r <= 13'(m * m);
    end
    if (cmd.w2) begin
      j3_r  <= 18'(j2_r * j_r);
      j2n_r <= 18'(j2_r * n_r);
      jn2_r <= 19'(n2_r * j_r);
      m3_r  <= 19'(m2_r * m);
    end
    if (cmd.w3) begin
      w_r[K_POS][0] <= tm3;
      w_r[K_POS][1] <= (tj3 <<< 1) + tj3 - (tj2n <<< 2) - (tj2n <<< 1) + (tn3 <<< 2);
      w_r[K_POS][2] <= tn3 - (tj3 <<< 1) - tj3 + (tj2n <<< 1) + tj2n
                       + (tjn2 <<< 1) + tjn2;
      w_r[K_POS][3] <= tj3;
      w_r[K_VEL][0] <= -tm2;
      w_r[K_VEL][1] <= (tj2 <<< 1) + tj2 - (tjn <<< 2);
      w_r[K_VEL][2] <= tn2 - (tj2 <<< 1) - tj2 + (tjn <<< 1);
      w_r[K_VEL][3] <= tj2;
      w_r[K_ACC][0] <= tn - tj;
      w_r[K_ACC][1] <= (tj <<< 1) + tj - (tn <<< 1);
      w_r[K_ACC][2] <= tn - (tj <<< 1) - tj;
      w_r[K_ACC][3] <= tj;
    end
    if (cmd.mac) begin
      if (cmd.tap == 2'd0) mac_r <= MACW'(prod);
      else mac_r <= mac_r + MACW'(prod);
    end
    if (cmd.dpre) begin
      neg_r <= a_s[MW-1];
      ovf_r <= (mag >= ((den << 1) << QW));
      rem_r <= mag;
      dvs_r <= (den << 1) << (QW - 1);
      quo_r <= '0;
    end
    if (cmd.div_step) begin
      if (rem_r >= dvs_r) begin
        rem_r <= rem_r - dvs_r;
        quo_r <= {quo_r[QW-2:0], 1'b1};
      end else begin
        quo_r <= {quo_r[QW-2:0], 1'b0};
      end
      dvs_r <= dvs_r >> 1;
    end
    if (cmd.dpost) begin
      case (cmd.kind)
        K_POS:   pos_r[cmd.comp] <= CW'(sat_q(qv, CW));
        K_VEL:   vel_r[cmd.comp] <= VW'(sat_q(qv, VW));
        K_ACC:   acc_r[cmd.comp] <= AW'(sat_q(qv, AW));
        default: acc_r[cmd.comp] <= AW'(sat_q(qv, AW));
      endcase
    end
    if (cmd.sq) begin
      if (cmd.comp == 2'd0) sq_r <= SQW'(ad * ad);
      else sq_r <= sq_r + SQW'(ad * ad);
    end
    if (cmd.sqrt_init) begin
      s_r   <= sq_r;
      r_r   <= '0;
      bit_r <= SQW'(1) << (2 * (SQRT_IT - 1));
    end
    if (cmd.sqrt_step) begin
      if (s_r >= rb) begin
        s_r <= s_r - rb;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.emit) begin
      for (int c = 0; c < 3; c++) begin
        o_pos[c]  <= pos_r[c];
        o_vel[c]  <= vel_r[c];
        o_acc[c]  <= acc_r[c];
        prev_r[c] <= pos_r[c];
      end
      o_len  <= sum[LEN_W] ? {LEN_W{1'b1}} : sum[LEN_W-1:0];
      o_last <= sts.last_j;
    end
  end

endmodule
`default_nettype wire

/* design/cbs_checker.sv */
// Port-level checks of the cubic B-spline sampler and their binding.
`default_nettype none
module cbs_checker
  import cbs_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_tvalid,
  input wire logic              in_tready,
  input wire logic              out_tvalid,
  input wire logic              out_tready,
  input wire logic [OUT_DW-1:0] out_tdata,
  input wire logic              out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("out word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(in_tvalid))
    else $error("input side went busy without a word");

  a_word_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result word appeared while idle");

  a_out_clear_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out valid after reset");

endmodule

bind cubic_bspline_sampler_core cbs_checker u_cbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire
